// ===== design/mchw_pkg.sv =====
// ----------------------------------------------------------------------------
// mchw_pkg: shared types and constants of the heartbeat watchdog
// field widths, action and status codes, config register indexes, the
// per-channel memory entry and the sequencer states
// ----------------------------------------------------------------------------
package mchw_pkg;

  // field widths
  localparam int ACTION_W = 2;
  localparam int ID_W     = 22;
  localparam int STATUS_W = 2;
  localparam int CHAN_W   = 4;
  localparam int CNT_W    = 12;

  // default channel count
  localparam int MAX_CHANNELS_DEF = 16;

  // config register map
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = ID_W;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID  = 1'b1;

  localparam logic [CNT_W-1:0] TIMEOUT_RESET = 12'd10;
  localparam logic [CNT_W-1:0] COUNT_MAX     = 12'hfff;
  localparam logic [ID_W-1:0]  OWN_ID_RESET  = '0;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_REGISTER  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_HEARTBEAT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK      = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_TRIPPED = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_HALTED  = 2'd3;

  // one channel as held in the state memory
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic             exempt;
    logic             mark;
    logic [CNT_W-1:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } fsm_t;

endpackage

// ===== design/mchw_in_if.sv =====
// ----------------------------------------------------------------------------
// mchw_in_if: request channel of the heartbeat watchdog
// valid/ready handshake carrying action, process id and exempt flag
// ----------------------------------------------------------------------------
interface mchw_in_if;
  logic                          valid;
  logic                          ready;
  logic [mchw_pkg::ACTION_W-1:0] action;
  logic [mchw_pkg::ID_W-1:0]     process_id;
  logic                          exempt;

  modport source (output valid, output action, output process_id, output exempt,
                  input ready);
  modport sink (input valid, input action, input process_id, input exempt,
                output ready);
endinterface

// ===== design/mchw_out_if.sv =====
// ----------------------------------------------------------------------------
// mchw_out_if: result channel of the heartbeat watchdog
// valid/ready handshake carrying status, channel, offender id and stop-all
// ----------------------------------------------------------------------------
interface mchw_out_if;
  logic                          valid;
  logic                          ready;
  logic [mchw_pkg::STATUS_W-1:0] status;
  logic [mchw_pkg::CHAN_W-1:0]   channel;
  logic [mchw_pkg::ID_W-1:0]     offender_id;
  logic                          stop_all;

  modport source (output valid, output status, output channel, output offender_id,
                  output stop_all, input ready);
  modport sink (input valid, input status, input channel, input offender_id,
                input stop_all, output ready);
endinterface

// ===== design/multi_channel_heartbeat_watchdog.sv =====
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_watchdog: heartbeat watchdog over a channel table
// channels are registered by id, heartbeats mark them, one-second ticks age
// them; the lowest non-exempt channel silent past the timeout trips the
// watchdog, which then reports stop-all until reset
// ----------------------------------------------------------------------------
//
//  port     | dir  | transfer payload
//  ---------+------+---------------------------------------------------
//  req      | in   | action, process_id, exempt
//  rsp      | out  | status, channel, offender_id, stop_all
//  cfg_*    | in   | cfg_index 0 timeout_seconds, 1 own_id (write only)
//
//  heartbeat and tick items with channels in use walk the channel memory
//  read port one entry per cycle until a hit, a trip or the last channel
//  in use (at most MAX_CHANNELS) sets the result; every other item sets
//  its result on the request transfer
//  reset is synchronous and instant: the fill count gates every read
//  a pending result waits in the result registers; req stays low until
//  that result can be handed to the output register
//
module multi_channel_heartbeat_watchdog #(
  parameter int MAX_CHANNELS = mchw_pkg::MAX_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  mchw_in_if.sink                         req,
  mchw_out_if.source                      rsp,
  input  logic                            cfg_we,
  input  logic [mchw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mchw_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int USED_W = $clog2(MAX_CHANNELS + 1);

  // config registers
  logic [mchw_pkg::CNT_W-1:0] timeout_seconds;
  logic [mchw_pkg::ID_W-1:0]  own_id;

  // control state
  mchw_pkg::fsm_t state, state_next;
  logic [USED_W-1:0] used;
  logic              halted;
  logic [IDX_W-1:0]  scan_idx;

  // item being worked on
  logic [mchw_pkg::ACTION_W-1:0] cur_action;
  logic [mchw_pkg::ID_W-1:0]     cur_pid;

  // result waiting for the output register
  logic [mchw_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic [IDX_W-1:0]              res_chan, res_chan_next;
  logic [mchw_pkg::ID_W-1:0]     res_id, res_id_next;
  logic                          res_stop, res_stop_next;

  // output register
  logic                          rsp_valid;
  logic [mchw_pkg::STATUS_W-1:0] rsp_status;
  logic [IDX_W-1:0]              rsp_chan;
  logic [mchw_pkg::ID_W-1:0]     rsp_id;
  logic                          rsp_stop;

  // memory ports
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  mchw_pkg::entry_t      ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [mchw_pkg::ENTRY_W-1:0] ram_rdata;

  // sequencer decisions
  logic req_xfer;
  logic res_set;
  logic scan_start;
  logic used_inc;
  logic halt_set;
  logic rsp_load;

  // entry under the walk
  mchw_pkg::entry_t ent, tick_ent, hb_ent;
  logic             trip, hb_hit, scan_last, table_full;

  mchw_ram #(
    .WIDTH (mchw_pkg::ENTRY_W),
    .DEPTH (MAX_CHANNELS)
  ) u_chan_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready  = (state == mchw_pkg::S_IDLE);
  assign req_xfer   = req.valid && req.ready;
  assign table_full = (used == USED_W'(MAX_CHANNELS));
  assign scan_last  = ((USED_W'(scan_idx) + USED_W'(1)) == used);
  assign rsp_load   = (state == mchw_pkg::S_DONE) && (!rsp_valid || rsp.ready);

  // age or refresh the entry read back from memory
  always_comb begin
    ent      = mchw_pkg::entry_t'(ram_rdata);
    tick_ent = ent;
    if (ent.mark) begin
      tick_ent.mark  = 1'b0;
      tick_ent.count = '0;
    end else if (ent.count != mchw_pkg::COUNT_MAX) begin
      tick_ent.count = ent.count + mchw_pkg::CNT_W'(1);
    end
    trip        = !ent.exempt && (tick_ent.count > timeout_seconds);
    hb_ent      = ent;
    hb_ent.mark = 1'b1;
    hb_hit      = (ent.id == cur_pid);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mchw_pkg::S_IDLE: begin
        if (req_xfer) begin
          state_next = scan_start ? mchw_pkg::S_SCAN : mchw_pkg::S_DONE;
        end
      end
      mchw_pkg::S_SCAN: begin
        if (res_set) begin
          state_next = mchw_pkg::S_DONE;
        end
      end
      mchw_pkg::S_DONE: begin
        if (rsp_load) begin
          state_next = mchw_pkg::S_IDLE;
        end
      end
      default: state_next = mchw_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs: memory access and result
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = used[IDX_W-1:0];
    ram_wdata       = '{id: req.process_id, exempt: req.exempt, mark: 1'b0, count: '0};
    ram_raddr       = '0;
    res_set         = 1'b0;
    res_status_next = mchw_pkg::STAT_OK;
    res_chan_next   = '0;
    res_id_next     = '0;
    res_stop_next   = 1'b0;
    scan_start      = 1'b0;
    used_inc        = 1'b0;
    halt_set        = 1'b0;
    case (state)
      mchw_pkg::S_IDLE: begin
        // entry 0 is read on the request transfer so the walk starts next cycle
        if (req_xfer) begin
          res_set = 1'b1;
          if (halted) begin
            res_status_next = mchw_pkg::STAT_HALTED;
            res_stop_next   = 1'b1;
          end else begin
            case (req.action)
              mchw_pkg::ACT_REGISTER: begin
                if (table_full || (req.process_id == own_id)) begin
                  res_status_next = mchw_pkg::STAT_IGNORED;
                end else begin
                  ram_we        = 1'b1;
                  used_inc      = 1'b1;
                  res_chan_next = used[IDX_W-1:0];
                end
              end
              mchw_pkg::ACT_HEARTBEAT: begin
                if (used == '0) begin
                  res_status_next = mchw_pkg::STAT_IGNORED;
                end else begin
                  res_set    = 1'b0;
                  scan_start = 1'b1;
                end
              end
              mchw_pkg::ACT_TICK: begin
                if (used != '0) begin
                  res_set    = 1'b0;
                  scan_start = 1'b1;
                end
              end
              default: res_status_next = mchw_pkg::STAT_IGNORED;
            endcase
          end
        end
      end
      mchw_pkg::S_SCAN: begin
        // read one ahead, write back the entry that just came out
        ram_raddr = scan_idx + IDX_W'(1);
        ram_waddr = scan_idx;
        if (cur_action == mchw_pkg::ACT_TICK) begin
          ram_we    = 1'b1;
          ram_wdata = tick_ent;
          if (trip) begin
            res_set         = 1'b1;
            res_status_next = mchw_pkg::STAT_TRIPPED;
            res_chan_next   = scan_idx;
            res_id_next     = ent.id;
            res_stop_next   = 1'b1;
            halt_set        = 1'b1;
          end else if (scan_last) begin
            res_set = 1'b1;
          end
        end else begin
          if (hb_hit) begin
            ram_we        = 1'b1;
            ram_wdata     = hb_ent;
            res_set       = 1'b1;
            res_chan_next = scan_idx;
          end else if (scan_last) begin
            res_set         = 1'b1;
            res_status_next = mchw_pkg::STAT_IGNORED;
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= mchw_pkg::S_IDLE;
      used            <= '0;
      halted          <= 1'b0;
      rsp_valid       <= 1'b0;
      timeout_seconds <= mchw_pkg::TIMEOUT_RESET;
      own_id          <= mchw_pkg::OWN_ID_RESET;
    end else begin
      state <= state_next;
      if (used_inc) begin
        used <= used + USED_W'(1);
      end
      if (halt_set) begin
        halted <= 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          mchw_pkg::CFG_TIMEOUT: timeout_seconds <= cfg_wdata[mchw_pkg::CNT_W-1:0];
          mchw_pkg::CFG_OWN_ID:  own_id <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      cur_action <= req.action;
      cur_pid    <= req.process_id;
    end
    if (scan_start) begin
      scan_idx <= '0;
    end else if (state == mchw_pkg::S_SCAN) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    if (res_set) begin
      res_status <= res_status_next;
      res_chan   <= res_chan_next;
      res_id     <= res_id_next;
      res_stop   <= res_stop_next;
    end
    if (rsp_load) begin
      rsp_status <= res_status;
      rsp_chan   <= res_chan;
      rsp_id     <= res_id;
      rsp_stop   <= res_stop;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.offender_id = rsp_id;
  assign rsp.stop_all    = rsp_stop;

  // channel index narrowed or widened to the 4-bit field
  generate
    if (IDX_W >= mchw_pkg::CHAN_W) begin : g_chan_trunc
      assign rsp.channel = rsp_chan[mchw_pkg::CHAN_W-1:0];
    end else begin : g_chan_ext
      assign rsp.channel = {{(mchw_pkg::CHAN_W - IDX_W){1'b0}}, rsp_chan};
    end
  endgenerate

`ifndef NO_ASSERTIONS
  // fill count never passes the table size
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= USED_W'(MAX_CHANNELS))
    else $error("channel fill count beyond table size");

  // the walk stays inside the filled part of the table
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == mchw_pkg::S_SCAN) |-> (USED_W'(scan_idx) < used))
    else $error("walk index outside filled channels");

  // a trip latches the halt for good
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt dropped without reset");

  // a trip shown on the result side was recorded as halted
  a_trip_halted: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status == mchw_pkg::STAT_TRIPPED)) |-> (halted && rsp_stop))
    else $error("trip reported without halt");
`endif

endmodule

// ===== design/mchw_ram.sv =====
// ----------------------------------------------------------------------------
// mchw_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module mchw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
